### rtl/hufd_pkg.sv
// Package for the Huffman tree-walk decoder: payload and node types,
// mode and register codes, node table sizing and index helpers.
// No dependencies.
package hufd_pkg;

    // Node table size; the table is addressed with NODE_AW bits.
    localparam int NODE_COUNT = 512;
    localparam int NODE_AW    = $clog2(NODE_COUNT);

    localparam int NIDX_W  = 9;
    localparam int SYM_W   = 8;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = $clog2(BYTE_W + 1);
    localparam int BITS_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_DECODE  = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_NODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BITS = 2'd1;

    typedef struct packed {
        logic [1:0]        mode;
        logic [BYTE_W-1:0] data_byte;
        logic [NIDX_W-1:0] node_index;
        logic [NIDX_W-1:0] left_child;
        logic [NIDX_W-1:0] right_child;
        logic              is_leaf;
        logic [SYM_W-1:0]  leaf_symbol;
    } hufd_in_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             stream_done;
    } hufd_out_t;

    // One node table entry, 27 bits.
    typedef struct packed {
        logic              is_leaf;
        logic [NIDX_W-1:0] left;
        logic [NIDX_W-1:0] right;
        logic [SYM_W-1:0]  symbol;
    } hufd_node_t;

    localparam int NODE_W = $bits(hufd_node_t);

    // Node table access from the walker.
    typedef struct packed {
        logic               we;
        logic [NODE_AW-1:0] waddr;
        hufd_node_t         wdata;
        logic               re;
        logic [NODE_AW-1:0] raddr;
    } hufd_ram_req_t;

    // Walker to result stage.
    typedef struct packed {
        logic             push;
        logic             flush;
        logic [SYM_W-1:0] symbol;
        logic             done;
    } hufd_emit_t;

    // Result stage to walker.
    typedef struct packed {
        logic hold;
    } hufd_ostat_t;

    function automatic logic [NODE_AW-1:0] node_addr(input logic [NIDX_W-1:0] idx);
        logic [NIDX_W+NODE_AW-1:0] wide;
        wide = {{NODE_AW{1'b0}}, idx};
        return wide[NODE_AW-1:0];
    endfunction

    function automatic logic node_in_range(input logic [NIDX_W-1:0] idx);
        logic [NIDX_W+NODE_AW:0] wide;
        logic [NIDX_W+NODE_AW:0] limit;
        wide  = {{(NODE_AW+1){1'b0}}, idx};
        limit = (NIDX_W + NODE_AW + 1)'(NODE_COUNT);
        return wide < limit;
    endfunction

endpackage

### rtl/hufd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hufd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### rtl/hufd_bit_walker.sv
// Bit-serial tree walker: config registers, coded-byte shift register,
// bit counter and node table sequencing. Depends on hufd_pkg.
module hufd_bit_walker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  hufd_pkg::hufd_in_t                 item,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hufd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hufd_pkg::CFG_DATA_W-1:0]    cfg_data,
    output hufd_pkg::hufd_ram_req_t            ram_req,
    input  hufd_pkg::hufd_node_t               ram_rdata,
    output hufd_pkg::hufd_emit_t               emit,
    input  hufd_pkg::hufd_ostat_t              ostat
);
    import hufd_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_ROOT, S_WALK, S_STEP, S_FLUSH} state_t;

    state_t              state_reg, state_next;
    logic [NIDX_W-1:0]   root_reg, root_next;
    logic [BITS_W-1:0]   total_reg, total_next;
    logic [NIDX_W-1:0]   walk_reg, walk_next;
    logic [BITS_W-1:0]   bits_done_reg, bits_done_next;
    logic [BYTE_W-1:0]   shift_reg, shift_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                pend_rd_reg, pend_rd_next;
    logic                rd_ok_reg, rd_ok_next;
    logic [NIDX_W-1:0]   child_reg, child_next;
    hufd_node_t          root_entry_reg, root_entry_next;
    hufd_node_t          cur_entry_reg, cur_entry_next;

    hufd_node_t          rd_e;
    hufd_node_t          base;
    logic [NIDX_W-1:0]   walk_now;
    logic [NIDX_W-1:0]   nidx;
    logic                leaf_hit;
    logic                step_hold;
    logic                more;
    logic                item_acc;

    always_comb
    begin
        state_next      = state_reg;
        root_next       = root_reg;
        total_next      = total_reg;
        walk_next       = walk_reg;
        bits_done_next  = bits_done_reg;
        shift_next      = shift_reg;
        cnt_next        = cnt_reg;
        pend_rd_next    = pend_rd_reg;
        rd_ok_next      = rd_ok_reg;
        child_next      = child_reg;
        root_entry_next = root_entry_reg;
        cur_entry_next  = cur_entry_reg;
        ram_req         = '0;
        emit            = '0;

        item_stall = (state_reg != S_IDLE);
        cfg_ready  = (state_reg == S_IDLE);
        item_acc   = item_valid && !item_stall;

        // Entries past the table end read as an inner node with zero children.
        rd_e      = rd_ok_reg ? ram_rdata : '0;
        leaf_hit  = pend_rd_reg && rd_e.is_leaf;
        step_hold = leaf_hit && ostat.hold;
        base      = pend_rd_reg ? (rd_e.is_leaf ? root_entry_reg : rd_e) : cur_entry_reg;
        walk_now  = pend_rd_reg ? (rd_e.is_leaf ? root_reg : child_reg) : walk_reg;
        more      = (cnt_reg != '0) && (bits_done_reg < total_reg);
        nidx      = shift_reg[BYTE_W-1] ? base.right : base.left;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ROOT_NODE:
                begin
                    root_next = cfg_data[NIDX_W-1:0];
                    walk_next = cfg_data[NIDX_W-1:0];
                end
                CFG_TOTAL_BITS:
                begin
                    total_next = cfg_data[BITS_W-1:0];
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_acc)
                begin
                    unique case (item.mode)
                        MODE_LOAD:
                        begin
                            ram_req.we    = node_in_range(item.node_index);
                            ram_req.waddr = node_addr(item.node_index);
                            ram_req.wdata = '{is_leaf: item.is_leaf,
                                              left:    item.left_child,
                                              right:   item.right_child,
                                              symbol:  item.leaf_symbol};
                        end
                        MODE_DECODE:
                        begin
                            shift_next  = item.data_byte;
                            cnt_next    = CNT_W'(BYTE_W);
                            ram_req.re    = 1'b1;
                            ram_req.raddr = node_addr(root_reg);
                            rd_ok_next  = node_in_range(root_reg);
                            state_next  = S_ROOT;
                        end
                        MODE_RESTART:
                        begin
                            bits_done_next = '0;
                            walk_next      = root_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ROOT:
            begin
                // Cache the root entry, then fetch the node the walk stands on.
                root_entry_next = rd_e;
                ram_req.re      = 1'b1;
                ram_req.raddr   = node_addr(walk_reg);
                rd_ok_next      = node_in_range(walk_reg);
                state_next      = S_WALK;
            end
            S_WALK:
            begin
                cur_entry_next = rd_e;
                pend_rd_next   = 1'b0;
                state_next     = S_STEP;
            end
            S_STEP:
            begin
                if (!step_hold)
                begin
                    emit.push      = leaf_hit;
                    emit.symbol    = rd_e.symbol;
                    emit.done      = (bits_done_reg >= total_reg);
                    walk_next      = walk_now;
                    cur_entry_next = base;
                    if (more)
                    begin
                        ram_req.re     = 1'b1;
                        ram_req.raddr  = node_addr(nidx);
                        rd_ok_next     = node_in_range(nidx);
                        child_next     = nidx;
                        bits_done_next = bits_done_reg + BITS_W'(1);
                        shift_next     = {shift_reg[BYTE_W-2:0], 1'b0};
                        cnt_next       = cnt_reg - CNT_W'(1);
                        pend_rd_next   = 1'b1;
                    end
                    else
                    begin
                        pend_rd_next = 1'b0;
                        state_next   = S_FLUSH;
                    end
                end
            end
            S_FLUSH:
            begin
                emit.flush = 1'b1;
                if (!ostat.hold)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            root_reg       <= '0;
            total_reg      <= '0;
            walk_reg       <= '0;
            bits_done_reg  <= '0;
            shift_reg      <= '0;
            cnt_reg        <= '0;
            pend_rd_reg    <= 1'b0;
            rd_ok_reg      <= 1'b0;
            child_reg      <= '0;
            root_entry_reg <= '0;
            cur_entry_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            root_reg       <= root_next;
            total_reg      <= total_next;
            walk_reg       <= walk_next;
            bits_done_reg  <= bits_done_next;
            shift_reg      <= shift_next;
            cnt_reg        <= cnt_next;
            pend_rd_reg    <= pend_rd_next;
            rd_ok_reg      <= rd_ok_next;
            child_reg      <= child_next;
            root_entry_reg <= root_entry_next;
            cur_entry_reg  <= cur_entry_next;
        end
    end
endmodule

### rtl/hufd_out_stage.sv
// Result stage: one pending symbol, so the last flag can be set at the end
// of a byte, followed by the output register. Depends on hufd_pkg.
module hufd_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hufd_pkg::hufd_emit_t  emit,
    output hufd_pkg::hufd_ostat_t ostat,
    output logic                  result_valid,
    input  logic                  result_stall,
    output hufd_pkg::hufd_out_t   result
);
    import hufd_pkg::*;

    logic             pend_valid_reg, pend_valid_next;
    logic [SYM_W-1:0] pend_sym_reg, pend_sym_next;
    logic             pend_done_reg, pend_done_next;
    logic             out_valid_reg, out_valid_next;
    hufd_out_t        out_reg, out_next;
    logic             out_busy;
    logic             move;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_done_next  = pend_done_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;

        out_busy = out_valid_reg && result_stall;
        move     = pend_valid_reg && !out_busy && (emit.push || emit.flush);

        ostat.hold = pend_valid_reg && out_busy;

        // Drain the output register first, then refill it from the pending slot.
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (move)
        begin
            out_next       = '{symbol: pend_sym_reg, last: emit.flush,
                               stream_done: pend_done_reg};
            out_valid_next = 1'b1;
        end

        if (emit.push)
        begin
            pend_valid_next = 1'b1;
            pend_sym_next   = emit.symbol;
            pend_done_next  = emit.done;
        end
        else if (move)
        begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_sym_reg   <= '0;
            pend_done_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            pend_sym_reg   <= pend_sym_next;
            pend_done_reg  <= pend_done_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;
endmodule

### rtl/huffman_tree_bit_decoder_top.sv
// Huffman tree-walk decoder, top level: node table RAM, bit-serial walker
// and result stage. Depends on hufd_pkg, hufd_ram, hufd_bit_walker, hufd_out_stage.
//
// The block decodes a Huffman bit stream by walking a code tree kept in a
// node table (NODE_COUNT entries of leaf flag, left child, right child and
// symbol). A load transaction (mode 0) writes one node and a restart
// transaction (mode 2) clears the bit count and returns the walk to the root;
// both produce no result. A decode transaction (mode 1) carries one coded
// byte whose bits are used most significant first: each bit steps to the
// right (1) or left (0) child, and every leaf reached yields one result
// with its symbol, after which the walk restarts at the root. The last
// result of a byte carries last = 1; stream_done is set on a result once
// total_bits coded bits have been consumed, and bits past that total are
// dropped. A decode transaction waits while the result channel stalls, and
// it walks its bits one after another: the node table has one read port,
// and each bit needs the entry of the child it reached before the next bit
// can step. The node table powers up undefined and must be loaded before
// it is walked. Registers (root_node at index 0, total_bits at index 1) are
// written through the cfg port while the block is idle; writing root_node
// also moves the walk to the new root.
module huffman_tree_bit_decoder_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  hufd_pkg::hufd_in_t              item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output hufd_pkg::hufd_out_t             result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hufd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hufd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hufd_pkg::*;

    hufd_ram_req_t ram_req;
    hufd_node_t    ram_rdata;
    logic [NODE_W-1:0] ram_rdata_bits;
    hufd_emit_t    emit;
    hufd_ostat_t   ostat;

    // Node table: written by load transactions, read once per walked bit and twice at the start of each decode.
    hufd_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_node_table (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata_bits)
    );

    assign ram_rdata = hufd_node_t'(ram_rdata_bits);

    // Walker: one coded bit per cycle out of the byte shift register while the result stage does not hold it.
    hufd_bit_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata),
        .emit       (emit),
        .ostat      (ostat)
    );

    // Result stage: hold one symbol back to mark the last of each byte.
    hufd_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .emit         (emit),
        .ostat        (ostat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );
endmodule

### rtl/hufd_checker.sv
// Port-level checker for the Huffman tree-walk decoder, bound to the top level.
// Depends on hufd_pkg and huffman_tree_bit_decoder_top.
module hufd_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    input  logic                            item_stall,
    input  hufd_pkg::hufd_in_t              item,
    input  logic                            result_valid,
    input  logic                            result_stall,
    input  hufd_pkg::hufd_out_t             result,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [hufd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hufd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hufd_pkg::*;

    // Hold a stalled result unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed or dropped");

    // A decode transaction occupies the walker on the next cycle.
    a_decode_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.mode == MODE_DECODE |=> item_stall)
        else $error("decode transaction did not occupy the walker");

    // Load, restart and unused modes leave the input open on the next cycle.
    a_other_free: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.mode != MODE_DECODE |=> !item_stall)
        else $error("non-decode transaction blocked the input");

    // Take configuration only while no transaction is in progress.
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready == !item_stall)
        else $error("config port open while decoding");
endmodule

bind huffman_tree_bit_decoder_top hufd_checker u_hufd_checker (.*);
